// ----- rtl/miller_rabin_trial_core_assert.svh -----
// Assertion macros for the Miller-Rabin trial core.
`ifndef MILLER_RABIN_TRIAL_CORE_ASSERT_SVH
`define MILLER_RABIN_TRIAL_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define MRT_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Implication checked in the cycle after its trigger.
`define MRT_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ----- rtl/mrt_pkg.sv -----
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared constants and types for the Miller-Rabin trial core.
// ----------------------------------------------------------------------------
package mrt_pkg;
  localparam int DEF_WIDTH = 32;
  localparam int IN_W      = 32;

  // Start request and operation select from the sequencer to the modular unit.
  typedef struct packed {
    logic start;
    logic is_mul;  // 1: modular multiply, 0: reduce of {a, b} by n
  } mrt_op_t;
endpackage

// ----- rtl/miller_rabin_trial_core.sv -----
// Each round issues its modular operations one after another on the shared
// bit-serial unit; trivial candidates (0 to 4 and even numbers) get a verdict
// without the unit.
// One word at a time: in_ready only while idle with no verdict pending.
// Reset (synchronous, rst high) clears sequencer, unit and output valid.
// ----------------------------------------------------------------------------
// miller_rabin_trial_core
// One Miller-Rabin round per input word, verdict in an output register.
// ----------------------------------------------------------------------------
`include "miller_rabin_trial_core_assert.svh"
module miller_rabin_trial_core import mrt_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] cand,
  input  logic [IN_W-1:0] rand_word,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            probably_prime
);
  mrt_op_t          op;
  logic [WIDTH-1:0] op_a, op_b, op_n, u_res;
  logic             u_busy, u_done, idle, fin, verdict;
  logic [WIDTH-1:0] n_in;

  always_comb begin
    n_in = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (i < IN_W) n_in[i] = cand[i];
    end
  end

  // fin means a verdict is on its way into the output register
  assign in_ready = idle && !out_valid && !fin;

  mrt_seq #(.WIDTH(WIDTH)) u_seq (
    .clk, .rst, .in_go(in_valid && in_ready), .n_in, .rnd_in(rand_word),
    .idle, .fin, .verdict, .op, .op_a, .op_b, .op_n, .u_done, .u_res
  );

  mrt_modunit #(.WIDTH(WIDTH)) u_mod (
    .clk, .rst, .op, .a(op_a), .b(op_b), .n(op_n),
    .busy(u_busy), .done(u_done), .res(u_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
      probably_prime <= verdict;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `MRT_ASSERT_IMP(a_fin_idle_out, clk, rst, fin, !out_valid, "result while output full")
  `MRT_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready, "word while busy")
  `MRT_ASSERT_IMP(a_done_busy, clk, rst, u_done, !u_busy, "unit done while busy")
endmodule

// ----- rtl/mrt_modunit.sv -----
// ----------------------------------------------------------------------------
// mrt_modunit
// Shared modular unit. Multiply: interleaved shift-add a*b mod n, one bit of
// b per cycle from the MSB. Reduce: restoring {a, b} mod n with a below n,
// one quotient bit per cycle. Operands of multiply must be below n.
// ----------------------------------------------------------------------------
module mrt_modunit import mrt_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  mrt_op_t          op,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] n,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] res
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc, opa, opb, modn;
  logic [CW-1:0]    cnt;
  logic             mul;

  logic [WIDTH:0] dbl, dsub, sum, ssub, acc1;
  logic [WIDTH-1:0] acc2;

  always_comb begin
    // multiply step: acc = 2*acc (+ a) mod n
    dbl  = {acc, 1'b0};
    dsub = dbl - {1'b0, modn};
    acc1 = dsub[WIDTH] ? dbl : dsub;
    sum  = acc1 + {1'b0, opa};
    ssub = sum - {1'b0, modn};
    if (opb[WIDTH-1]) begin
      acc2 = ssub[WIDTH] ? sum[WIDTH-1:0] : ssub[WIDTH-1:0];
    end else begin
      acc2 = acc1[WIDTH-1:0];
    end
    if (!mul) begin
      // reduce step: remainder = 2*rem + next dividend bit
      dbl  = {acc, opb[WIDTH-1]};
      dsub = dbl - {1'b0, modn};
      acc2 = dsub[WIDTH] ? dbl[WIDTH-1:0] : dsub[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (op.start && !busy) begin
      busy <= 1'b1;
      mul  <= op.is_mul;
      // reduce carries the running remainder in through a
      acc  <= op.is_mul ? '0 : a;
      opa  <= a;
      opb  <= b;
      modn <= n;
      cnt  <= CW'(WIDTH);
    end else if (busy) begin
      acc <= acc2;
      opb <= {opb[WIDTH-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign res = acc;
endmodule

// ----- rtl/mrt_seq.sv -----
// ----------------------------------------------------------------------------
// mrt_seq
// Round sequencer: special cases, d/r split, witness reduction, square and
// multiply, then the squaring chain.
// ----------------------------------------------------------------------------
module mrt_seq import mrt_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_go,
  input  logic [WIDTH-1:0] n_in,
  input  logic [IN_W-1:0]  rnd_in,
  output logic             idle,
  output logic             fin,
  output logic             verdict,
  output mrt_op_t          op,
  output logic [WIDTH-1:0] op_a,
  output logic [WIDTH-1:0] op_b,
  output logic [WIDTH-1:0] op_n,
  input  logic             u_done,
  input  logic [WIDTH-1:0] u_res
);
  localparam int RW   = $clog2(WIDTH + 1);
  localparam int RC   = (IN_W + WIDTH - 1) / WIDTH;  // reduce chunks of rnd
  localparam int RNDW = RC * WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_RED, S_REDW, S_EXP, S_EXPW, S_SQB, S_SQBW, S_CHK,
    S_SQ, S_SQW, S_END
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] n, d, x, base, nm1;
  logic [RNDW-1:0]  rnd;
  logic [RW-1:0]    r;
  logic [$clog2(RC+1)-1:0] chunk;
  logic [WIDTH-1:0] rem;

  always_ff @(posedge clk) begin
    fin <= 1'b0;
    op.start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_go) begin
            n <= n_in;
            rnd <= RNDW'(rnd_in);
            nm1 <= n_in - 1'b1;
            d <= n_in - 1'b1;
            r <= '0;
            rem <= '0;
            chunk <= '0;
            if (n_in <= WIDTH'(1) || n_in == WIDTH'(4) || !n_in[0] && n_in > WIDTH'(3))
            begin
              verdict <= 1'b0;
              state <= S_END;
            end else if (n_in <= WIDTH'(3)) begin
              verdict <= 1'b1;
              state <= S_END;
            end else begin
              state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          if (!d[0]) begin
            d <= d >> 1;
            r <= r + 1'b1;
          end else begin
            state <= S_RED;
          end
        end
        // rnd mod (n-4), WIDTH bits of rnd per pass: rem = (rem:chunk) mod m
        S_RED: begin
          if (32'(chunk) == 32'(RC)) begin
            base <= rem + WIDTH'(2);
            x <= WIDTH'(1);
            state <= S_EXP;
          end else begin
            op.start <= 1'b1;
            op.is_mul <= 1'b0;
            op_a <= rem;
            op_b <= rnd[RNDW-1 -: WIDTH];
            op_n <= n - WIDTH'(4);
            state <= S_REDW;
          end
        end
        S_REDW: begin
          if (u_done) begin
            rem <= u_res;
            rnd <= rnd << WIDTH;
            chunk <= chunk + 1'b1;
            state <= S_RED;
          end
        end
        S_EXP: begin
          if (d == '0) begin
            state <= S_CHK;
          end else if (d[0]) begin
            op.start <= 1'b1;
            op.is_mul <= 1'b1;
            op_a <= x;
            op_b <= base;
            op_n <= n;
            state <= S_EXPW;
          end else begin
            state <= S_SQB;
          end
        end
        S_EXPW: begin
          if (u_done) begin
            x <= u_res;
            state <= S_SQB;
          end
        end
        S_SQB: begin
          op.start <= 1'b1;
          op.is_mul <= 1'b1;
          op_a <= base;
          op_b <= base;
          op_n <= n;
          state <= S_SQBW;
        end
        S_SQBW: begin
          if (u_done) begin
            base <= u_res;
            d <= d >> 1;
            state <= S_EXP;
          end
        end
        S_CHK: begin
          if (x == WIDTH'(1) || x == nm1) begin
            verdict <= 1'b1;
            state <= S_END;
          end else if (r <= RW'(1)) begin
            verdict <= 1'b0;
            state <= S_END;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          op.start <= 1'b1;
          op.is_mul <= 1'b1;
          op_a <= x;
          op_b <= x;
          op_n <= n;
          r <= r - 1'b1;
          state <= S_SQW;
        end
        S_SQW: begin
          if (u_done) begin
            x <= u_res;
            if (u_res == WIDTH'(1)) begin
              verdict <= 1'b0;
              state <= S_END;
            end else if (u_res == nm1) begin
              verdict <= 1'b1;
              state <= S_END;
            end else if (r <= RW'(1)) begin
              verdict <= 1'b0;
              state <= S_END;
            end else begin
              state <= S_SQ;
            end
          end
        end
        S_END: begin
          fin <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE);
endmodule
